// ----- rtl/core/wlp_pkg.sv -----
// Shared package of the wavetable loop player.
// Holds request, register and mode codes, controller states and the command and status
// structs that join the controller to the datapath. Depends on nothing.
`default_nettype none

package wlp_pkg;

    localparam int FRAME_SIZE_DEF  = 32;
    localparam int TABLE_DEPTH_DEF = 16384;

    localparam int POS_W  = 15;
    localparam int ADDR_W = 14;
    localparam int SMP_W  = 16;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_START   = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_RENDER  = 2'd3
    } req_t;

    localparam logic [2:0] CFG_ATTACK_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_LOOP_LENGTH    = 3'd1;
    localparam logic [2:0] CFG_SAMPLE_STEP    = 3'd2;
    localparam logic [2:0] CFG_RELEASE_DECAY  = 3'd3;
    localparam logic [2:0] CFG_RELEASE_FRAMES = 3'd4;

    typedef enum logic [1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_SUSTAIN  = 2'd1,
        MODE_RELEASE  = 2'd2
    } env_mode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WADDR1,
        S_WADDR2,
        S_WRITE,
        S_FMUL,
        S_FDIV1,
        S_FDIV2,
        S_FCAP,
        S_SAMPLE,
        S_WRAP,
        S_ADR1,
        S_ADR2,
        S_RD0,
        S_RD1,
        S_CAP1,
        S_IMUL,
        S_IMIX,
        S_GMUL,
        S_OUT,
        S_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic accept_write;
        logic accept_start;
        logic accept_release;
        logic accept_render;
        logic addr_sel_wr;
        logic mem_wr;
        logic fall_mul;
        logic fall_cap;
        logic step_phase;
        logic wrap;
        logic mem_rd0;
        logic mem_rd1;
        logic cap_s0;
        logic cap_s1;
        logic imul;
        logic imix;
        logic gmul;
        logic out_load;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic inactive;
        logic direct;
        logic out_free;
        logic last_sample;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/wlp_cdiv.sv -----
// Two-stage divider of an unsigned value by a constant, by reciprocal multiply and one
// correction step. Used for table address reduction and the release fall. Uses no package.
`default_nettype none

module wlp_cdiv #(
    parameter int W       = 16,
    parameter int DIVISOR = 32
) (
    input  wire logic         aclk,
    input  wire logic [W-1:0] x,
    output logic      [W-1:0] quot,
    output logic      [W-1:0] rem
);

    localparam logic [W:0]  RECIP = (W+1)'((2**W) / DIVISOR);
    localparam logic [W:0]  DLOW  = (W+1)'(DIVISOR);
    localparam logic [31:0] DWIDE = 32'(DIVISOR);

    logic [2*W:0] prod;
    logic [W-1:0] x_reg;
    logic [W-1:0] q_reg;
    logic [W:0]   qd;
    logic [W:0]   r_raw;
    logic         fix;
    logic [W-1:0] quot_reg;
    logic [W-1:0] rem_reg;

    assign prod  = {{(W+1){1'b0}}, x} * {{W{1'b0}}, RECIP};
    assign qd    = {1'b0, q_reg} * DLOW;
    assign r_raw = {1'b0, x_reg} - qd;
    assign fix   = (32'(r_raw) >= DWIDE);

    always_ff @(posedge aclk) begin
        x_reg    <= x;
        q_reg    <= prod[2*W-1:W];
        quot_reg <= q_reg + W'(fix);
        rem_reg  <= fix ? W'(r_raw - DLOW) : W'(r_raw);
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/wlp_ctrl.sv -----
// Controller state machine of the wavetable loop player.
// Sequences table writes, note events and frame rendering; depends on wlp_pkg.
`default_nettype none

module wlp_ctrl
    import wlp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [1:0] s_req_type,
    output logic            s_ready,
    input  wire sts_t       sts,
    output cmd_t            cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    req_t        req;

    assign req = req_t'(s_req_type);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (req)
                        REQ_WRITE:  state_next = S_WADDR1;
                        REQ_RENDER: state_next = sts.inactive ? S_IDLE : S_FMUL;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_WADDR1: state_next = S_WADDR2;
            S_WADDR2: state_next = S_WRITE;
            S_WRITE:  state_next = S_IDLE;
            S_FMUL:   state_next = S_FDIV1;
            S_FDIV1:  state_next = S_FDIV2;
            S_FDIV2:  state_next = S_FCAP;
            S_FCAP:   state_next = S_SAMPLE;
            S_SAMPLE: state_next = sts.direct ? S_ADR1 : S_WRAP;
            S_WRAP:   state_next = S_ADR1;
            S_ADR1:   state_next = S_ADR2;
            S_ADR2:   state_next = S_RD0;
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = sts.direct ? S_GMUL : S_CAP1;
            S_CAP1:   state_next = S_IMUL;
            S_IMUL:   state_next = S_IMIX;
            S_IMIX:   state_next = S_GMUL;
            S_GMUL:   state_next = S_OUT;
            S_OUT: begin
                if (sts.out_free) begin
                    state_next = sts.last_sample ? S_FIN : S_SAMPLE;
                end
            end
            S_FIN:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept_write   = (req == REQ_WRITE);
                    cmd.accept_start   = (req == REQ_START);
                    cmd.accept_release = (req == REQ_RELEASE);
                    cmd.accept_render  = (req == REQ_RENDER);
                end
            end
            S_WADDR1: cmd.addr_sel_wr = 1'b1;
            S_WRITE:  cmd.mem_wr = 1'b1;
            S_FMUL:   cmd.fall_mul = 1'b1;
            S_FCAP:   cmd.fall_cap = 1'b1;
            S_SAMPLE: cmd.step_phase = !sts.direct;
            S_WRAP:   cmd.wrap = 1'b1;
            S_RD0:    cmd.mem_rd0 = 1'b1;
            S_RD1: begin
                cmd.mem_rd1 = 1'b1;
                cmd.cap_s0  = 1'b1;
            end
            S_CAP1:   cmd.cap_s1 = 1'b1;
            S_IMUL:   cmd.imul = 1'b1;
            S_IMIX:   cmd.imix = 1'b1;
            S_GMUL:   cmd.gmul = 1'b1;
            S_OUT:    cmd.out_load = sts.out_free;
            S_FIN:    cmd.finish = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/wlp_datapath.sv -----
// Datapath of the wavetable loop player: registers, table memory, phase and position
// arithmetic, interpolation, gain and envelope. Depends on wlp_pkg and wlp_cdiv.
`default_nettype none

module wlp_datapath
    import wlp_pkg::*;
#(
    parameter int FRAME_SIZE  = FRAME_SIZE_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic [13:0]        s_table_addr,
    input  wire logic signed [15:0] s_table_sample,
    input  wire logic [15:0]        s_start_gain,
    input  wire logic signed [15:0] s_phase_step,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic signed [15:0]      m_audio_sample,
    output logic                    m_last_in_frame,
    output logic                    m_note_active
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
    localparam logic [CW-1:0] LAST_CNT = CW'(FRAME_SIZE - 1);
    localparam logic [15:0]   FSUB     = 16'(FRAME_SIZE - 1);

    logic [13:0] attack_reg;
    logic [13:0] loop_len_reg;
    logic [2:0]  step_reg;
    logic [15:0] decay_reg;
    logic [15:0] rel_frames_reg;

    logic [POS_W-1:0] pos_reg;
    logic [15:0]      phase_reg;
    logic [15:0]      gain_reg;
    env_mode_t        mode_reg;
    logic [15:0]      left_reg;
    logic [CW-1:0]    cnt_reg;
    logic             m_valid_reg;

    logic [ADDR_W-1:0] wr_addr_reg;
    logic [15:0]       wr_data_reg;
    logic signed [15:0] pstep_reg;
    logic              direct_reg;
    logic              active_reg;
    logic [31:0]       fprod_reg;
    logic [15:0]       fall_reg;
    logic [15:0]       rdata_reg;
    logic signed [15:0] s0_reg;
    logic signed [15:0] s1_reg;
    logic signed [33:0] iprod_reg;
    logic signed [16:0] v_reg;
    logic signed [33:0] gprod_reg;
    logic signed [15:0] out_sample_reg;
    logic              out_last_reg;
    logic              out_active_reg;

    logic [15:0] mem [TABLE_DEPTH];

    logic [13:0]       len;
    logic [2:0]        stp;
    logic [POS_W-1:0]  loop_end;
    logic              rel_last;
    logic [15:0]       fdiv_x;
    logic [15:0]       fdiv_q;
    logic [POS_W-1:0]  ax0;
    logic [POS_W-1:0]  ax1;
    logic [POS_W-1:0]  r0;
    logic [POS_W-1:0]  r1;
    logic [AW-1:0]     raddr;
    logic signed [17:0] psum;
    logic [POS_W-1:0]  pdelta;
    logic [POS_W-1:0]  pos_step_next;
    logic signed [16:0] ph17;
    logic signed [16:0] diff;
    logic signed [33:0] iprod_next;
    logic signed [33:0] isum;
    logic signed [17:0] vsum;
    logic signed [16:0] gain17;
    logic signed [16:0] vsel;
    logic signed [33:0] gprod_next;
    logic signed [33:0] gsum;
    logic signed [18:0] gshift;
    logic signed [15:0] sat_next;
    logic [15:0]        gain_next;
    logic [15:0]        left_next;

    always_comb begin
        len = (loop_len_reg == 14'd0) ? 14'd1 : loop_len_reg;
        if (step_reg inside {[3'd1:3'd4]}) begin
            stp = step_reg;
        end else if (step_reg == 3'd0) begin
            stp = 3'd1;
        end else begin
            stp = 3'd4;
        end
    end

    assign loop_end = {1'b0, attack_reg} + {1'b0, len};
    assign rel_last = (left_reg <= 16'd1);
    assign fdiv_x   = rel_last ? gain_reg + FSUB : fprod_reg[31:16];

    wlp_cdiv #(.W(16), .DIVISOR(FRAME_SIZE)) u_fall_div (
        .aclk (aclk),
        .x    (fdiv_x),
        .quot (fdiv_q),
        .rem  ()
    );

    assign ax0 = cmd.addr_sel_wr ? {1'b0, wr_addr_reg} : pos_reg;
    assign ax1 = pos_reg + 15'd1;

    wlp_cdiv #(.W(POS_W), .DIVISOR(TABLE_DEPTH)) u_addr0_div (
        .aclk (aclk),
        .x    (ax0),
        .quot (),
        .rem  (r0)
    );

    wlp_cdiv #(.W(POS_W), .DIVISOR(TABLE_DEPTH)) u_addr1_div (
        .aclk (aclk),
        .x    (ax1),
        .quot (),
        .rem  (r1)
    );

    assign raddr = cmd.mem_rd1 ? AW'(r1) : AW'(r0);

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[AW'(r0)] <= wr_data_reg;
        end
        if (cmd.mem_rd0 || cmd.mem_rd1) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign psum   = $signed({2'b00, phase_reg}) + 18'(pstep_reg);
    assign pdelta = psum[17] ? {POS_W{1'b1}} : (psum[16] ? 15'd1 : 15'd0);
    assign pos_step_next = pos_reg + {12'd0, stp} + pdelta;

    assign ph17       = $signed({1'b0, phase_reg});
    assign diff       = $signed({s1_reg[15], s1_reg}) - $signed({s0_reg[15], s0_reg});
    assign iprod_next = ph17 * diff;
    assign isum       = iprod_reg + 34'sd32768;
    assign vsum       = $signed({{2{s0_reg[15]}}, s0_reg}) + isum[33:16];

    assign gain17     = $signed({1'b0, gain_reg});
    assign vsel       = direct_reg ? $signed({s0_reg[15], s0_reg}) : v_reg;
    assign gprod_next = gain17 * vsel;
    assign gsum       = gprod_reg + 34'sd16384;
    assign gshift     = gsum[33:15];

    always_comb begin
        if (gshift > 19'sd32767) begin
            sat_next = 16'sh7FFF;
        end else if (gshift < -19'sd32768) begin
            sat_next = -16'sh8000;
        end else begin
            sat_next = gshift[15:0];
        end
    end

    assign gain_next = (gain_reg > fall_reg) ? gain_reg - fall_reg : 16'd0;
    assign left_next = (left_reg > 16'd0) ? left_reg - 16'd1 : 16'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg     <= 14'd0;
            loop_len_reg   <= 14'd1;
            step_reg       <= 3'd1;
            decay_reg      <= 16'd0;
            rel_frames_reg <= 16'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ATTACK_LENGTH:  attack_reg     <= cfg_wdata[13:0];
                CFG_LOOP_LENGTH:    loop_len_reg   <= cfg_wdata[13:0];
                CFG_SAMPLE_STEP:    step_reg       <= cfg_wdata[2:0];
                CFG_RELEASE_DECAY:  decay_reg      <= cfg_wdata;
                CFG_RELEASE_FRAMES: rel_frames_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            phase_reg   <= 16'd0;
            gain_reg    <= 16'd0;
            mode_reg    <= MODE_INACTIVE;
            left_reg    <= 16'd0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept_start) begin
                gain_reg  <= (s_start_gain > 16'd32768) ? 16'd32768 : s_start_gain;
                pos_reg   <= '0;
                phase_reg <= 16'd0;
                mode_reg  <= MODE_SUSTAIN;
            end
            if (cmd.accept_release && mode_reg == MODE_SUSTAIN) begin
                mode_reg <= MODE_RELEASE;
                left_reg <= (rel_frames_reg == 16'd0) ? 16'd1 : rel_frames_reg;
            end
            if (cmd.accept_render) begin
                cnt_reg <= '0;
            end
            if (cmd.step_phase) begin
                phase_reg <= psum[15:0];
                pos_reg   <= pos_step_next;
            end
            if (cmd.wrap && pos_reg >= loop_end) begin
                pos_reg <= pos_reg - {1'b0, len};
            end
            if (cmd.out_load) begin
                gain_reg <= gain_next;
                cnt_reg  <= cnt_reg + CW'(1);
                if (direct_reg) begin
                    pos_reg <= pos_reg + 15'd1;
                end
            end
            if (cmd.finish && mode_reg == MODE_RELEASE) begin
                left_reg <= left_next;
                if (left_next == 16'd0) begin
                    mode_reg <= MODE_INACTIVE;
                    gain_reg <= 16'd0;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept_write) begin
            wr_addr_reg <= s_table_addr;
            wr_data_reg <= s_table_sample;
        end
        if (cmd.accept_render) begin
            pstep_reg  <= s_phase_step;
            direct_reg <= (pos_reg < {1'b0, attack_reg});
            active_reg <= !(mode_reg == MODE_RELEASE && rel_last);
        end
        if (cmd.fall_mul) begin
            fprod_reg <= 32'(gain_reg) * 32'(decay_reg);
        end
        if (cmd.fall_cap) begin
            fall_reg <= (mode_reg == MODE_RELEASE) ? fdiv_q : 16'd0;
        end
        if (cmd.cap_s0) begin
            s0_reg <= rdata_reg;
        end
        if (cmd.cap_s1) begin
            s1_reg <= rdata_reg;
        end
        if (cmd.imul) begin
            iprod_reg <= iprod_next;
        end
        if (cmd.imix) begin
            v_reg <= vsum[16:0];
        end
        if (cmd.gmul) begin
            gprod_reg <= gprod_next;
        end
        if (cmd.out_load) begin
            out_sample_reg <= sat_next;
            out_last_reg   <= (cnt_reg == LAST_CNT);
            out_active_reg <= active_reg;
        end
    end

    assign sts.inactive    = (mode_reg == MODE_INACTIVE);
    assign sts.direct      = direct_reg;
    assign sts.out_free    = !m_valid_reg || m_ready;
    assign sts.last_sample = (cnt_reg == LAST_CNT);

    assign m_valid         = m_valid_reg;
    assign m_audio_sample  = out_sample_reg;
    assign m_last_in_frame = out_last_reg;
    assign m_note_active   = out_active_reg;

endmodule

`default_nettype wire

// ----- rtl/core/wavetable_loop_player.sv -----
// Top level of the wavetable loop player: controller, datapath and checks.
// Depends on wlp_pkg, wlp_ctrl, wlp_datapath and wlp_cdiv.
`default_nettype none

// The block plays a wavetable with an attack part read word by word and a loop part
// read at a fractional phase with linear interpolation, scaled by a gain envelope.
// Items are taken one at a time. A render frame also waits while the output register
// is still full. Each looped sample is set by two reads of the single-port table, the
// constant-divisor address reduction and the interpolation and gain multiplies done one
// per cycle. The last sample of a frame may wait for its transfer while the next item
// is accepted. No clearing pass is needed after reset.
module wavetable_loop_player
    import wlp_pkg::*;
#(
    parameter int FRAME_SIZE  = FRAME_SIZE_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [13:0]        s_table_addr,
    input  wire logic signed [15:0] s_table_sample,
    input  wire logic [15:0]        s_start_gain,
    input  wire logic signed [15:0] s_phase_step,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_audio_sample,
    output logic                    m_last_in_frame,
    output logic                    m_note_active
);

    cmd_t cmd;
    sts_t sts;

    wlp_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    wlp_datapath #(
        .FRAME_SIZE  (FRAME_SIZE),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_table_addr    (s_table_addr),
        .s_table_sample  (s_table_sample),
        .s_start_gain    (s_start_gain),
        .s_phase_step    (s_phase_step),
        .cmd             (cmd),
        .sts             (sts),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_audio_sample  (m_audio_sample),
        .m_last_in_frame (m_last_in_frame),
        .m_note_active   (m_note_active)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("A result was loaded over one that was not yet transferred.");

    a_silent_inactive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.inactive)
        else $error("A result was produced while the note was inactive.");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.mem_rd0 || cmd.mem_rd1 || cmd.out_load))
        else $error("An item was offered while frame work was still running.");

    a_frame_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && sts.last_sample) |=> (cmd.finish && !cmd.out_load))
        else $error("The frame did not close after its last sample.");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for wavetable_loop_player: table load, directed rows and random notes.
// Predicts every frame sample in-line and checks each transfer on the result channel.
// Depends on wlp_pkg and the wavetable_loop_player top level.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wlp_pkg::*;

    localparam int FRAME = FRAME_SIZE_DEF;
    localparam int DEPTH = TABLE_DEPTH_DEF;

    typedef struct {
        logic [15:0] smp;
        bit          last;
        bit          active;
    } frame_sample_t;

    typedef struct {
        req_t        req;
        logic [13:0] addr;
        logic [15:0] smp;
        logic [15:0] gain;
        logic [15:0] pstep;
        bit          typed;
        int          n_typed;
        logic [15:0] t_sample;
        bit          t_active;
    } stim_row_t;

    typedef struct {
        logic [13:0] attack;
        logic [13:0] loop_len;
        logic [2:0]  step;
        logic [15:0] decay;
        logic [15:0] frames;
    } setting_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type = '0;
    logic [13:0]        s_table_addr = '0;
    logic signed [15:0] s_table_sample = '0;
    logic [15:0]        s_start_gain = '0;
    logic signed [15:0] s_phase_step = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_audio_sample;
    logic               m_last_in_frame;
    logic               m_note_active;

    wavetable_loop_player DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_table_addr   (s_table_addr),
        .s_table_sample (s_table_sample),
        .s_start_gain   (s_start_gain),
        .s_phase_step   (s_phase_step),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_audio_sample (m_audio_sample),
        .m_last_in_frame(m_last_in_frame),
        .m_note_active  (m_note_active)
    );

    always #4 aclk = ~aclk;

    // Voice state as the block should hold it.
    logic [15:0] wt [DEPTH];
    logic [14:0] v_pos = '0;
    logic [15:0] v_phase = '0;
    longint      v_gain = 0;
    env_mode_t   v_mode = MODE_INACTIVE;
    logic [15:0] v_left = '0;

    logic [13:0] r_attack = 14'd0;
    logic [13:0] r_loop = 14'd1;
    logic [2:0]  r_step = 3'd1;
    logic [15:0] r_decay = 16'd0;
    logic [15:0] r_frames = 16'd1;

    frame_sample_t due_samples[$];
    int            mismatches = 0;

    stim_row_t   cur_row;
    bit          calm = 1'b1;
    int          phase_items = 0;
    logic [15:0] set_frames = 16'd1;

    function automatic longint word_at(logic [14:0] a);
        return longint'($signed(wt[int'(a) % DEPTH]));
    endfunction

    function automatic logic [15:0] gain_scale(longint g, longint v);
        longint r;
        r = (g * v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    task automatic voice_step(input logic [1:0] req, input logic [13:0] addr,
                              input logic [15:0] smp, input logic [15:0] g,
                              input logic signed [15:0] ps, input bit keep);
        longint        len, stp, loop_end, fall, pstep, p, s0, s1, v;
        bit            direct, active_after;
        frame_sample_t fs;
        case (req)
            REQ_WRITE: begin
                wt[int'(addr) % DEPTH] = smp;
            end
            REQ_START: begin
                v_gain = (g > 16'd32768) ? 32768 : g;
                v_pos = '0;
                v_phase = '0;
                v_mode = MODE_SUSTAIN;
            end
            REQ_RELEASE: begin
                if (v_mode == MODE_SUSTAIN) begin
                    v_mode = MODE_RELEASE;
                    v_left = (r_frames == 0) ? 16'd1 : r_frames;
                end
            end
            default: begin
                if (v_mode != MODE_INACTIVE) begin
                    len = (r_loop == 0) ? 1 : r_loop;
                    stp = (r_step < 1) ? 1 : ((r_step > 4) ? 4 : r_step);
                    loop_end = r_attack + len;
                    pstep = ps;
                    direct = v_pos < r_attack;
                    fall = 0;
                    if (v_mode == MODE_RELEASE) begin
                        if (v_left > 1) fall = (v_gain * r_decay) / (FRAME * 65536);
                        else fall = (v_gain + FRAME - 1) / FRAME;
                    end
                    active_after = !(v_mode == MODE_RELEASE && v_left <= 1);
                    for (int k = 0; k < FRAME; k++) begin
                        if (direct) begin
                            v = word_at(v_pos);
                            v_pos = v_pos + 15'd1;
                        end else begin
                            p = longint'(v_phase) + pstep;
                            if (p >= 65536) begin
                                p = p - 65536;
                                v_pos = v_pos + 15'd1;
                            end else if (p < 0) begin
                                p = p + 65536;
                                v_pos = v_pos - 15'd1;
                            end
                            v_phase = p[15:0];
                            v_pos = v_pos + stp;
                            if (v_pos >= loop_end) v_pos = v_pos - len;
                            s0 = word_at(v_pos);
                            s1 = word_at(v_pos + 15'd1);
                            v = s0 + ((p * (s1 - s0) + 32768) >>> 16);
                        end
                        fs.smp = gain_scale(v_gain, v);
                        fs.last = (k == FRAME - 1);
                        fs.active = active_after;
                        if (keep) due_samples.push_back(fs);
                        v_gain = (v_gain > fall) ? v_gain - fall : 0;
                    end
                    if (v_mode == MODE_RELEASE) begin
                        v_left = (v_left > 0) ? v_left - 16'd1 : 16'd0;
                        if (v_left == 0) begin
                            v_mode = MODE_INACTIVE;
                            v_gain = 0;
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        frame_sample_t want, typed_fs;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ATTACK_LENGTH:  r_attack = cfg_wdata[13:0];
                    CFG_LOOP_LENGTH:    r_loop = cfg_wdata[13:0];
                    CFG_SAMPLE_STEP:    r_step = cfg_wdata[2:0];
                    CFG_RELEASE_DECAY:  r_decay = cfg_wdata;
                    CFG_RELEASE_FRAMES: r_frames = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                voice_step(s_req_type, s_table_addr, s_table_sample, s_start_gain,
                           s_phase_step, !cur_row.typed);
                if (cur_row.typed) begin
                    for (int k = 0; k < cur_row.n_typed; k++) begin
                        typed_fs.smp = cur_row.t_sample;
                        typed_fs.last = (k == FRAME - 1);
                        typed_fs.active = cur_row.t_active;
                        due_samples.push_back(typed_fs);
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (due_samples.size() == 0) begin
                    note_mismatch("unexpected sample", $signed(m_audio_sample), 0);
                end else begin
                    want = due_samples.pop_front();
                    if (m_audio_sample !== want.smp)
                        note_mismatch("audio_sample", $signed(m_audio_sample),
                                      $signed(want.smp));
                    if (m_last_in_frame !== want.last)
                        note_mismatch("last_in_frame", m_last_in_frame, want.last);
                    if (m_note_active !== want.active)
                        note_mismatch("note_active", m_note_active, want.active);
                end
            end
        end
    end

    initial begin : receiver
        int w;
        wait (aresetn);
        forever begin
            w = calm ? 0 : $urandom_range(0, 10);
            if (w > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (w - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic stim_row_t mk(req_t rq, int a, int s, int g, int ps,
                                     bit ty, int nt, int ts, bit ta);
        stim_row_t r;
        r.req = rq;
        r.addr = a;
        r.smp = s;
        r.gain = g;
        r.pstep = ps;
        r.typed = ty;
        r.n_typed = nt;
        r.t_sample = ts;
        r.t_active = ta;
        return r;
    endfunction

    function automatic stim_row_t rand_row(req_t rq);
        return mk(rq, $urandom, $urandom, $urandom, $urandom, 1'b0, 0, 0, 1'b0);
    endfunction

    task automatic send_row(input stim_row_t r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        cur_row = r;
        s_valid <= 1'b1;
        s_req_type <= r.req;
        s_table_addr <= r.addr;
        s_table_sample <= r.smp;
        s_start_gain <= r.gain;
        s_phase_step <= r.pstep;
        phase_items++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    // Holds the sender off until every predicted sample has been seen, then lets
    // a table write or an inactive render still in flight finish.
    task automatic settle();
        @(negedge aclk) s_valid <= 1'b0;
        while (due_samples.size() != 0) @(negedge aclk);
        repeat (32) @(negedge aclk);
    endtask

    task automatic play_note();
        stim_row_t r;
        int        n, eff, rel;
        r = rand_row(REQ_START);
        if ($urandom_range(0, 7) != 0) r.gain = $urandom_range(0, 32768);
        send_row(r);
        n = $urandom_range(1, 4);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) send_row(rand_row(REQ_WRITE));
            r = rand_row(REQ_RENDER);
            if ($urandom_range(0, 2) == 0) r.pstep = $urandom_range(0, 4095) - 2048;
            send_row(r);
        end
        if ($urandom_range(0, 5) == 0) begin
            send_row(rand_row(REQ_START));
            send_row(rand_row(REQ_RENDER));
        end
        send_row(rand_row(REQ_RELEASE));
        if ($urandom_range(0, 3) == 0) send_row(rand_row(REQ_RELEASE));
        eff = (set_frames == 0) ? 1 : set_frames;
        rel = $urandom_range(1, (eff < 6) ? eff : 6);
        repeat (rel) send_row(rand_row(REQ_RENDER));
        if ($urandom_range(0, 2) == 0) send_row(rand_row(req_t'($urandom_range(0, 3))));
    endtask

    initial begin : sender
        stim_row_t dir_rows[$];
        setting_t  plan[$];
        setting_t  st;
        stim_row_t r;
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Every table word is loaded first, so no read can reach an unwritten entry.
        calm = 1'b1;
        for (int a = 0; a < DEPTH; a++) begin
            r = rand_row(REQ_WRITE);
            r.addr = a;
            send_row(r);
        end
        calm = 1'b0;

        dir_rows.push_back(mk(REQ_RENDER,  0,     0,       0,       0,       1, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RELEASE, 0,     0,       0,       0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_WRITE,   0,     'h7FFF,  0,       0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_START,   0,     0,       'h8000,  0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RENDER,  0,     0,       0,       0,       1, FRAME, 'h7FFF,  1));
        dir_rows.push_back(mk(REQ_WRITE,   0,     'h8000,  0,       0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RENDER,  0,     0,       0,       0,       1, FRAME, 'h8000,  1));
        dir_rows.push_back(mk(REQ_START,   0,     0,       'hFFFF,  0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RENDER,  0,     0,       0,       'h7FFF,  0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RENDER,  0,     0,       0,       'h8000,  0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_START,   0,     0,       0,       0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RENDER,  0,     0,       0,       0,       1, FRAME, 0,       1));
        dir_rows.push_back(mk(REQ_WRITE,   'h3FFF, 'h5A5A, 0,       0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_WRITE,   1,     'h8001,  0,       0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_START,   0,     0,       'h4000,  0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RENDER,  0,     0,       0,       'h3039,  0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RELEASE, 0,     0,       0,       0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RELEASE, 0,     0,       0,       0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RENDER,  0,     0,       0,       'hC000,  0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RENDER,  0,     0,       0,       0,       1, 0,     0,       0));
        dir_rows.push_back(mk(REQ_START,   0,     0,       'h7FFF,  0,       0, 0,     0,       0));
        dir_rows.push_back(mk(REQ_RENDER,  0,     0,       0,       'hFFFF,  0, 0,     0,       0));
        foreach (dir_rows[i]) send_row(dir_rows[i]);
        settle();

        plan.push_back('{14'd0,     14'd0,     3'd0, 16'd0,     16'd0});
        plan.push_back('{14'd16383, 14'd16383, 3'd4, 16'd65535, 16'd65535});
        plan.push_back('{14'd40,    14'd100,   3'd7, 16'd65535, 16'd3});
        plan.push_back('{14'd10,    14'd5,     3'd5, 16'd32768, 16'd2});
        repeat (8) begin
            st.attack = $urandom_range(0, 80);
            st.loop_len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 120);
            st.step = $urandom_range(0, 7);
            st.decay = $urandom;
            st.frames = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
            plan.push_back(st);
        end

        foreach (plan[i]) begin
            write_reg(CFG_ATTACK_LENGTH, plan[i].attack);
            write_reg(CFG_LOOP_LENGTH, plan[i].loop_len);
            write_reg(CFG_SAMPLE_STEP, plan[i].step);
            write_reg(CFG_RELEASE_DECAY, plan[i].decay);
            write_reg(CFG_RELEASE_FRAMES, plan[i].frames);
            set_frames = plan[i].frames;
            calm = (i % 4 == 3);
            phase_items = 0;
            while (phase_items < 30) play_note();
            settle();
        end
        repeat (32) @(negedge aclk);

        if (mismatches == 0 && due_samples.size() == 0) begin
            $display("[wavetable_loop_player] OK");
        end else begin
            $display("[wavetable_loop_player] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("[wavetable_loop_player] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/wlp_pkg.sv
rtl/core/wlp_cdiv.sv
rtl/core/wlp_ctrl.sv
rtl/core/wlp_datapath.sv
rtl/core/wavetable_loop_player.sv
bench/tb.sv
